/* hdl/bpg_pkg.sv */
// Shared types, constants and the micro-op table of the Bezier patch grid point unit.
`timescale 1ns / 1ps
`default_nettype none
package bpg_pkg;

    localparam int COORD_W  = 24;
    localparam int LEN_W    = 23;
    localparam int ADDR_W   = 5;
    localparam int DIV_W    = 40;
    localparam int T_W      = 17;
    localparam int PT_N     = 12;
    localparam int OP_N     = 20;

    localparam logic [15:0] FRAC_033 = 16'd21627;
    localparam logic [15:0] FRAC_067 = 16'd43909;

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_INIT = 2'd1;
    localparam logic [1:0] ACT_EVAL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RES   = 2'd0;
    localparam logic [1:0] CFG_SCOL  = 2'd1;
    localparam logic [1:0] CFG_SROW  = 2'd2;

    // scratch slots above the 24 point words
    localparam logic [ADDR_W-1:0] SL_SX = 5'd24;
    localparam logic [ADDR_W-1:0] SL_EX = 5'd25;
    localparam logic [ADDR_W-1:0] SL_M1 = 5'd26;
    localparam logic [ADDR_W-1:0] SL_M2 = 5'd27;
    localparam logic [ADDR_W-1:0] SL_T0 = 5'd28;
    localparam logic [ADDR_W-1:0] SL_T1 = 5'd29;
    localparam logic [ADDR_W-1:0] SL_T2 = 5'd30;
    localparam logic [ADDR_W-1:0] SL_NO = 5'd31;

    typedef struct packed {
        logic              use_u;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] d;
    } t_op;

    // One lerp per entry: side curves at k, inner blends at k, final cubic at u.
    function automatic t_op op_lookup(input logic [4:0] n);
        t_op o;
        case (n)
            5'd0:  o = '{1'b0, 5'd0,  5'd4,  SL_T0};
            5'd1:  o = '{1'b0, 5'd4,  5'd11, SL_T1};
            5'd2:  o = '{1'b0, 5'd11, 5'd3,  SL_T2};
            5'd3:  o = '{1'b0, SL_T0, SL_T1, SL_T0};
            5'd4:  o = '{1'b0, SL_T1, SL_T2, SL_T1};
            5'd5:  o = '{1'b0, SL_T0, SL_T1, SL_SX};
            5'd6:  o = '{1'b0, 5'd1,  5'd7,  SL_T0};
            5'd7:  o = '{1'b0, 5'd7,  5'd8,  SL_T1};
            5'd8:  o = '{1'b0, 5'd8,  5'd2,  SL_T2};
            5'd9:  o = '{1'b0, SL_T0, SL_T1, SL_T0};
            5'd10: o = '{1'b0, SL_T1, SL_T2, SL_T1};
            5'd11: o = '{1'b0, SL_T0, SL_T1, SL_EX};
            5'd12: o = '{1'b0, 5'd5,  5'd10, SL_M1};
            5'd13: o = '{1'b0, 5'd6,  5'd9,  SL_M2};
            5'd14: o = '{1'b1, SL_SX, SL_M1, SL_T0};
            5'd15: o = '{1'b1, SL_M1, SL_M2, SL_T1};
            5'd16: o = '{1'b1, SL_M2, SL_EX, SL_T2};
            5'd17: o = '{1'b1, SL_T0, SL_T1, SL_T0};
            5'd18: o = '{1'b1, SL_T1, SL_T2, SL_T1};
            5'd19: o = '{1'b1, SL_T0, SL_T1, SL_NO};
            default: o = '{1'b0, SL_NO, SL_NO, SL_NO};
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

/* hdl/bezier_patch_grid_point_unit.sv */
// Top level of the Bezier patch grid point unit: sequencer, point store and shared multiplier.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | in        | i_in_valid / o_in_stall   | action, point, rectangle, grid row/col
//  out     | out       | o_out_valid / i_out_stall | vertex index, x, y, tex u, tex v
//  cfg     | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Work per item: a load writes x then y, a rectangle initialisation computes four fractions and
// writes 24 point words, a grid point runs four divisions on the bit-serial divider and 40
// lerps on the single multiplier with its one write port into the point store.
// Reset clears the sequencer, the registers to their defaults and the point valid bits;
// a point never written reads as zero.
// While an item is at work or a result waits, o_in_stall stays high; a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none
module bezier_patch_grid_point_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_point_index,
    input  wire logic signed [23:0] i_point_x,
    input  wire logic signed [23:0] i_point_y,
    input  wire logic [22:0] i_rect_w,
    input  wire logic [22:0] i_rect_h,
    input  wire logic [7:0]  i_grid_row,
    input  wire logic [7:0]  i_grid_col,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_vertex_index,
    output logic signed [23:0] o_vertex_x,
    output logic signed [23:0] o_vertex_y,
    output logic [31:0]      o_tex_u,
    output logic [31:0]      o_tex_v
);
    typedef enum logic [3:0] {
        S_IDLE, S_LD0, S_LD1, S_IMUL, S_IWR, S_PREP, S_DIV, S_MUL, S_LERP, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0]  r_cfg_res;
    logic [31:0] r_scol, r_srow;

    // captured item
    logic [3:0]  r_idx;
    logic [23:0] r_px, r_py;
    logic [22:0] r_w, r_h;
    logic [7:0]  r_res, r_row, r_col;

    // sequencer
    logic [4:0]  r_cnt;
    logic [1:0]  r_phase;
    logic        r_pass;
    logic [1:0]  r_dsel;
    logic        r_dgo;
    logic [bpg_pkg::DIV_W-1:0] r_dvd;

    // arithmetic state
    logic [22:0] r_w3, r_w6, r_h3, r_h6;
    logic [bpg_pkg::T_W-1:0] r_k, r_u;
    logic [23:0] r_rda, r_rdb, r_la;
    logic signed [50:0] r_prod;

    // result
    logic        r_ovalid;
    logic [15:0] r_vidx;
    logic [23:0] r_vx, r_vy;
    logic [31:0] r_tu, r_tv;

    // point store: x words 0-11, y words 12-23, scratch 24-31
    logic [23:0] r_mem [32];
    logic [23:0] r_vld;

    logic                      div_done;
    logic [bpg_pkg::DIV_W-1:0] div_quo;

    bpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_dgo),
        .i_dvd   (r_dvd),
        .i_dvs   (r_res),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- operand selection ----------------
    bpg_pkg::t_op op;
    logic [4:0]  ra, rb, rd;
    logic        accept;
    logic [24:0] diff;
    logic signed [32:0] m_a;
    logic signed [17:0] m_b;
    logic signed [50:0] m_p;
    logic signed [50:0] rnd;
    logic [24:0] lsum;
    logic [23:0] lres;
    logic [3:0]  ipt;
    logic        iy;
    logic [22:0] ioff;
    logic [24:0] isum;
    logic [23:0] isat;
    logic        w_we;
    logic [4:0]  w_wa;
    logic [23:0] w_wd;
    logic [7:0]  res_eff;

    assign accept = i_in_valid && !o_in_stall;
    assign res_eff = (r_cfg_res == 8'd0) ? 8'd1 : r_cfg_res;

    always_comb begin
        op = bpg_pkg::op_lookup(r_cnt);
        ra = (r_pass && op.a < 5'(bpg_pkg::PT_N)) ? 5'(op.a + 5'(bpg_pkg::PT_N)) : op.a;
        rb = (r_pass && op.b < 5'(bpg_pkg::PT_N)) ? 5'(op.b + 5'(bpg_pkg::PT_N)) : op.b;
        rd = op.d;
    end

    // shared multiplier: rectangle fractions, texture products, lerp differences
    assign diff = {r_rdb[23], r_rdb} - {r_rda[23], r_rda};
    always_comb begin
        m_a = {{8{diff[24]}}, diff};
        m_b = {1'b0, (op.use_u ? r_u : r_k)};
        case (r_state)
            S_IMUL: begin
                m_a = {10'd0, (r_cnt[1] ? r_h : r_w)};
                m_b = {2'd0, (r_cnt[0] ? bpg_pkg::FRAC_067 : bpg_pkg::FRAC_033)};
            end
            S_MUL: begin
                m_a = {1'b0, (r_dsel == 2'd2 ? r_scol : r_srow)};
                m_b = {10'd0, (r_dsel == 2'd2 ? r_col : r_row)};
            end
            default: ;
        endcase
    end
    assign m_p = m_a * m_b;

    // round half up then floor: stays between the two end points
    assign rnd  = r_prod + 51'sd32768;
    assign lsum = {r_la[23], r_la} + 25'(rnd >>> 16);
    assign lres = lsum[23:0];

    // rectangle initialisation: point and offset for this sweep step
    always_comb begin
        iy  = (r_cnt >= 5'(bpg_pkg::PT_N));
        ipt = iy ? 4'(r_cnt - 5'(bpg_pkg::PT_N)) : r_cnt[3:0];
        ioff = '0;
        if (!iy) begin
            case (ipt)
                4'd1, 4'd2, 4'd7, 4'd8: ioff = r_w;
                4'd5, 4'd10:            ioff = r_w3;
                4'd6, 4'd9:             ioff = r_w6;
                default:                ioff = '0;
            endcase
        end else begin
            case (ipt)
                4'd2, 4'd3, 4'd9, 4'd10: ioff = r_h;
                4'd4, 4'd7:              ioff = r_h3;
                4'd8, 4'd11:             ioff = r_h6;
                default:                 ioff = '0;
            endcase
        end
        isum = {(iy ? r_py[23] : r_px[23]), (iy ? r_py : r_px)} + {2'b00, ioff};
        // only the upper bound can be crossed: the offset is never negative
        isat = (!isum[24] && isum[23]) ? 24'h7FFFFF : isum[23:0];
    end

    // write port of the point store
    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        case (r_state)
            S_LD0: begin
                w_we = 1'b1;
                w_wa = {1'b0, r_idx};
                w_wd = r_px;
            end
            S_LD1: begin
                w_we = 1'b1;
                w_wa = 5'({1'b0, r_idx} + 5'(bpg_pkg::PT_N));
                w_wd = r_py;
            end
            S_IWR: begin
                w_we = 1'b1;
                w_wa = r_cnt;
                w_wd = isat;
            end
            S_LERP: begin
                w_we = (r_phase == 2'd2);
                w_wa = rd;
                w_wd = lres;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rda <= (ra >= 5'd24 || r_vld[ra]) ? r_mem[ra] : '0;
        r_rdb <= (rb >= 5'd24 || r_vld[rb]) ? r_mem[rb] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we && w_wa < 5'd24) begin
            r_vld[w_wa] <= 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_res <= 8'd16;
            r_scol    <= 32'h0001_0000;
            r_srow    <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpg_pkg::CFG_RES:  r_cfg_res <= i_cfg_data[7:0];
                bpg_pkg::CFG_SCOL: r_scol    <= i_cfg_data;
                bpg_pkg::CFG_SROW: r_srow    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dgo    <= 1'b0;
            r_cnt    <= '0;
            r_phase  <= '0;
            r_pass   <= 1'b0;
            r_dsel   <= '0;
        end else begin
            r_dgo <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= i_point_index;
                        r_px  <= i_point_x;
                        r_py  <= i_point_y;
                        r_w   <= i_rect_w;
                        r_h   <= i_rect_h;
                        r_res <= res_eff;
                        r_row <= (i_grid_row > res_eff) ? res_eff : i_grid_row;
                        r_col <= (i_grid_col > res_eff) ? res_eff : i_grid_col;
                        r_cnt <= '0;
                        case (i_action)
                            bpg_pkg::ACT_LOAD:
                                r_state <= (i_point_index < 4'(bpg_pkg::PT_N)) ? S_LD0 : S_IDLE;
                            bpg_pkg::ACT_INIT: r_state <= S_IMUL;
                            bpg_pkg::ACT_EVAL: r_state <= S_PREP;
                            default:           r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LD0: r_state <= S_LD1;
                S_LD1: r_state <= S_IDLE;
                S_IMUL: begin
                    case (r_cnt[1:0])
                        2'd0:    r_w3 <= 23'((m_p + 51'sd32768) >>> 16);
                        2'd1:    r_w6 <= 23'((m_p + 51'sd32768) >>> 16);
                        2'd2:    r_h3 <= 23'((m_p + 51'sd32768) >>> 16);
                        default: r_h6 <= 23'((m_p + 51'sd32768) >>> 16);
                    endcase
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_IWR;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_IWR: begin
                    if (r_cnt == 5'(2 * bpg_pkg::PT_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_PREP: begin
                    r_vidx  <= 16'(r_row * ({1'b0, r_res} + 9'd1)) + {8'd0, r_col};
                    r_dvd   <= {16'd0, r_row, 16'd0} + 40'(r_res >> 1);
                    r_dsel  <= 2'd0;
                    r_dgo   <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        case (r_dsel)
                            2'd0: begin
                                r_k     <= div_quo[bpg_pkg::T_W-1:0];
                                r_dvd   <= {16'd0, r_col, 16'd0} + 40'(r_res >> 1);
                                r_dsel  <= 2'd1;
                                r_dgo   <= 1'b1;
                            end
                            2'd1: begin
                                r_u     <= div_quo[bpg_pkg::T_W-1:0];
                                r_dsel  <= 2'd2;
                                r_state <= S_MUL;
                            end
                            2'd2: begin
                                r_tu    <= (|div_quo[39:32]) ? '1 : div_quo[31:0];
                                r_dsel  <= 2'd3;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_tv    <= (|div_quo[39:32]) ? '1 : div_quo[31:0];
                                r_cnt   <= '0;
                                r_phase <= '0;
                                r_pass  <= 1'b0;
                                r_state <= S_LERP;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_dvd   <= 40'(m_p) + 40'(r_res >> 1);
                    r_dgo   <= 1'b1;
                    r_state <= S_DIV;
                end
                S_LERP: begin
                    case (r_phase)
                        2'd0: r_phase <= 2'd1;
                        2'd1: begin
                            r_prod  <= m_p;
                            r_la    <= r_rda;
                            r_phase <= 2'd2;
                        end
                        default: begin
                            r_phase <= 2'd0;
                            if (r_cnt == 5'(bpg_pkg::OP_N - 1)) begin
                                r_cnt <= '0;
                                if (r_pass) begin
                                    r_vy     <= lres;
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_vx   <= lres;
                                    r_pass <= 1'b1;
                                end
                            end else begin
                                r_cnt <= r_cnt + 5'd1;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_vertex_index = r_vidx;
    assign o_vertex_x     = r_vx;
    assign o_vertex_y     = r_vy;
    assign o_tex_u        = r_tu;
    assign o_tex_v        = r_tv;

`ifndef SYNTH
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("result pending while input open");
    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV) else $error("divider finished outside divide step");
    a_lerp_scratch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LERP && w_we) |-> w_wa >= 5'd24)
        else $error("lerp wrote a patch point");
    a_lerp_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LERP |-> !o_out_valid) else $error("result shown during lerp sweep");
`endif
endmodule
`default_nettype wire

/* hdl/bpg_div.sv */
// Restoring divider, one quotient bit per cycle, for the grid fractions and texture coordinates.
`timescale 1ns / 1ps
`default_nettype none
module bpg_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire logic [bpg_pkg::DIV_W-1:0]  i_dvd,
    input  wire logic [7:0]                 i_dvs,
    output logic                            o_done,
    output logic [bpg_pkg::DIV_W-1:0]       o_quo
);
    logic [bpg_pkg::DIV_W-1:0] r_q;
    logic [7:0]                r_rem;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [8:0]                trial;
    logic                      fits;

    assign trial = {r_rem, r_q[bpg_pkg::DIV_W-1]};
    assign fits  = (trial >= {1'b0, i_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dvd;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[bpg_pkg::DIV_W-2:0], fits};
                r_rem <= fits ? 8'(trial - {1'b0, i_dvs}) : trial[7:0];
                if (r_cnt == 6'(bpg_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

/* tb/sv/tb_bezier_patch_grid_point_unit.sv */
// Testbench of the Bezier patch grid point unit: directed table, random phases, self-checking.
`timescale 1ns / 1ps
module tb_bezier_patch_grid_point_unit;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 400;   // enough for a grid point to finish
    localparam int HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ACT_NONE = 3;         // spare action code, ignored by the block
    localparam logic [1:0] CFG_NONE = 2'd3;  // spare register index, dropped by the block

    typedef struct packed {
        logic [15:0]        vidx;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [31:0]        tu;
        logic [31:0]        tv;
    } t_vertex;

    typedef struct packed {
        logic [1:0]         act;
        logic [3:0]         pidx;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [22:0]        rw;
        logic [22:0]        rh;
        logic [7:0]         row;
        logic [7:0]         col;
        logic               typed;
        t_vertex            vtx;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_action = '0;
    logic [3:0] i_point_index = '0;
    logic signed [23:0] i_point_x = '0;
    logic signed [23:0] i_point_y = '0;
    logic [22:0] i_rect_w = '0;
    logic [22:0] i_rect_h = '0;
    logic [7:0] i_grid_row = '0;
    logic [7:0] i_grid_col = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [15:0] o_vertex_index;
    logic signed [23:0] o_vertex_x;
    logic signed [23:0] o_vertex_y;
    logic [31:0] o_tex_u;
    logic [31:0] o_tex_v;

    bezier_patch_grid_point_unit DUT (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow of the block: patch points and registers
    logic signed [23:0] pts_x [bpg_pkg::PT_N];
    logic signed [23:0] pts_y [bpg_pkg::PT_N];
    logic [7:0]  grid_res;
    logic [31:0] scale_col;
    logic [31:0] scale_row;

    t_vertex pending_vertices [$];
    int  n_err = 0;
    bit  calm = 1'b0;        // no idling on either side
    bit  hold_req = 1'b0;    // ask the receiver for a long hold-off
    int  quiet_cycles = 0;

    // a + floor(((b - a) * t + 0.5) / 1.0) with t in Q1.16
    function automatic logic signed [23:0] blend(logic signed [23:0] a,
                                                 logic signed [23:0] b, longint t);
        longint v;
        v = (longint'(b) - longint'(a)) * t + 32768;
        return 24'(longint'(a) + (v >>> 16));
    endfunction

    function automatic logic signed [23:0] bezier3(logic signed [23:0] p0, logic signed [23:0] p1,
                                                   logic signed [23:0] p2, logic signed [23:0] p3,
                                                   longint t);
        logic signed [23:0] a, b, c;
        a = blend(p0, p1, t);
        b = blend(p1, p2, t);
        c = blend(p2, p3, t);
        return blend(blend(a, b, t), blend(b, c, t), t);
    endfunction

    function automatic logic signed [23:0] clip24(longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return 24'(v);
    endfunction

    function automatic longint rect_frac(logic [22:0] len, logic [15:0] frac);
        return (longint'(len) * longint'(frac) + 32768) >>> 16;
    endfunction

    // Update the shadow state for one accepted item; return 1 with the vertex for an evaluation
    function automatic bit predict_vertex(t_stim_row s, output t_vertex v);
        longint ox [bpg_pkg::PT_N], oy [bpg_pkg::PT_N];
        longint res, r, c, k, u, w3, w6, h3, h6, w, h;
        logic signed [23:0] sx, sy, ex, ey, m1x, m1y, m2x, m2y;
        longint unsigned tu, tv;
        v = '0;
        case (s.act)
            bpg_pkg::ACT_LOAD: begin
                if (s.pidx < bpg_pkg::PT_N) begin
                    pts_x[s.pidx] = s.px;
                    pts_y[s.pidx] = s.py;
                end
                return 1'b0;
            end
            bpg_pkg::ACT_INIT: begin
                w = s.rw;
                h = s.rh;
                w3 = rect_frac(s.rw, bpg_pkg::FRAC_033);
                w6 = rect_frac(s.rw, bpg_pkg::FRAC_067);
                h3 = rect_frac(s.rh, bpg_pkg::FRAC_033);
                h6 = rect_frac(s.rh, bpg_pkg::FRAC_067);
                ox = '{0, w, w, 0, 0, w3, w6, w, w, w6, w3, 0};
                oy = '{0, 0, h, h, h3, 0, 0, h3, h6, h, h, h6};
                for (int i = 0; i < bpg_pkg::PT_N; i++) begin
                    pts_x[i] = clip24(longint'(s.px) + ox[i]);
                    pts_y[i] = clip24(longint'(s.py) + oy[i]);
                end
                return 1'b0;
            end
            bpg_pkg::ACT_EVAL: begin
                res = (grid_res == 0) ? 1 : grid_res;
                r = (s.row > res) ? res : s.row;
                c = (s.col > res) ? res : s.col;
                k = (r * 65536 + res / 2) / res;
                u = (c * 65536 + res / 2) / res;
                sx = bezier3(pts_x[0], pts_x[4], pts_x[11], pts_x[3], k);
                sy = bezier3(pts_y[0], pts_y[4], pts_y[11], pts_y[3], k);
                ex = bezier3(pts_x[1], pts_x[7], pts_x[8], pts_x[2], k);
                ey = bezier3(pts_y[1], pts_y[7], pts_y[8], pts_y[2], k);
                m1x = blend(pts_x[5], pts_x[10], k);
                m1y = blend(pts_y[5], pts_y[10], k);
                m2x = blend(pts_x[6], pts_x[9], k);
                m2y = blend(pts_y[6], pts_y[9], k);
                tu = (longint'(c) * scale_col + res / 2) / res;
                tv = (longint'(r) * scale_row + res / 2) / res;
                v.vidx = 16'(r * (res + 1) + c);
                v.vx = bezier3(sx, m1x, m2x, ex, u);
                v.vy = bezier3(sy, m1y, m2y, ey, u);
                v.tu = (tu > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(tu);
                v.tv = (tv > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(tv);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then log the expectation
    task automatic send_item(t_stim_row s);
        t_vertex v;
        if (!calm && $urandom_range(99) < 20) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_action = s.act;
        i_point_index = s.pidx;
        i_point_x = s.px;
        i_point_y = s.py;
        i_rect_w = s.rw;
        i_rect_h = s.rh;
        i_grid_row = s.row;
        i_grid_col = s.col;
        do @(posedge i_clk); while (o_in_stall);
        if (s.typed) pending_vertices.push_back(s.vtx);
        else if (predict_vertex(s, v)) pending_vertices.push_back(v);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            bpg_pkg::CFG_RES:  grid_res = data[7:0];
            bpg_pkg::CFG_SCOL: scale_col = data;
            bpg_pkg::CFG_SROW: scale_row = data;
            default: ;
        endcase
    endtask

    // Wait for every result, then let a grid point's worth of cycles pass
    task automatic drain();
        while (pending_vertices.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly evaluations inside the grid; loads, initialisations and spare codes around them
    function automatic t_stim_row random_item();
        t_stim_row s;
        int pick;
        int lim;
        s = '0;
        s.px = 24'($urandom);
        s.py = 24'($urandom);
        s.rw = 23'($urandom);
        s.rh = 23'($urandom);
        s.pidx = 4'($urandom);
        lim = (grid_res == 0) ? 1 : grid_res;
        s.row = ($urandom_range(99) < 75) ? 8'($urandom_range(0, lim)) : 8'($urandom);
        s.col = ($urandom_range(99) < 75) ? 8'($urandom_range(0, lim)) : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 20) begin
            s.act = bpg_pkg::ACT_LOAD;
            if ($urandom_range(99) < 20) begin
                // small coordinates keep the curve arithmetic away from the rails
                s.px = 24'(signed'(12'($urandom)));
                s.py = 24'(signed'(12'($urandom)));
            end
        end else if (pick < 30) begin
            s.act = bpg_pkg::ACT_INIT;
        end else if (pick < 95) begin
            s.act = bpg_pkg::ACT_EVAL;
        end else begin
            s.act = 2'(ACT_NONE);
        end
        return s;
    endfunction

    // Receiver: random stalls, calm stretches and one long hold-off
    always @(negedge i_clk) begin
        int hold_cnt;
        if (hold_req) begin
            hold_req = 1'b0;
            i_out_stall <= 1'b1;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    // Check each transfer on the result channel against the oldest expectation
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: unexpected vertex %0d", $time, o_vertex_index);
                n_err++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_vertex_index !== want.vidx) begin
                    $display("%0t: vertex_index exp %0d got %0d", $time, want.vidx,
                             o_vertex_index);
                    n_err++;
                end
                if (o_vertex_x !== want.vx) begin
                    $display("%0t: vertex_x exp %0d got %0d", $time, want.vx, o_vertex_x);
                    n_err++;
                end
                if (o_vertex_y !== want.vy) begin
                    $display("%0t: vertex_y exp %0d got %0d", $time, want.vy, o_vertex_y);
                    n_err++;
                end
                if (o_tex_u !== want.tu) begin
                    $display("%0t: tex_u exp %h got %h", $time, want.tu, o_tex_u);
                    n_err++;
                end
                if (o_tex_v !== want.tv) begin
                    $display("%0t: tex_v exp %h got %h", $time, want.tv, o_tex_v);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bezier_patch_grid_point_unit: done, errors");
            $finish;
        end
    end

    // Directed rows: reset state, clamping, ignored codes, saturating initialisation
    t_stim_row directed [20] = '{
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd0, 8'd0, 1'b1,
          '{16'd0, 24'sd0, 24'sd0, 32'd0, 32'd0}},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd255, 8'd255, 1'b1,
          '{16'd288, 24'sd0, 24'sd0, 32'd65536, 32'd65536}},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd3, 8'd5, 1'b1,
          '{16'd56, 24'sd0, 24'sd0, 32'd20480, 32'd12288}},
        '{bpg_pkg::ACT_INIT, 4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd7, 8'd9, 1'b1,
          '{16'd128, 24'sh7FFFFF, 24'sh7FFFFF, 32'd36864, 32'd28672}},
        '{bpg_pkg::ACT_INIT, 4'd0, 24'sh800000, 24'sh800000, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd16, 8'd0, 1'b1,
          '{16'd272, 24'sh800000, 24'sh800000, 32'd0, 32'd65536}},
        '{bpg_pkg::ACT_INIT, 4'd0, -24'sd2560, 24'sd1280, 23'd5120, 23'd2560,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd8, 8'd8, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd16, 8'd16, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd5, 24'sh7FFFFF, 24'sh800000, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd10, 24'sh800000, 24'sh7FFFFF, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd15, 24'sd77, 24'sd99, 23'd0, 23'd0, 8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd12, 24'sh7FFFFF, 24'sh7FFFFF, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd5, 8'd11, 1'b0, '0},
        '{2'(ACT_NONE), 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd1, 8'd1, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd11, 24'sh7FFFFF, 24'sh800000, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_LOAD, 4'd0, 24'sh800000, 24'sh7FFFFF, 23'd0, 23'd0,
          8'd0, 8'd0, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd9, 8'd200, 1'b0, '0},
        '{bpg_pkg::ACT_EVAL, 4'd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 8'd255, 8'd3, 1'b0, '0}
    };

    initial begin
        for (int i = 0; i < bpg_pkg::PT_N; i++) begin
            pts_x[i] = '0;
            pts_y[i] = '0;
        end
        grid_res = 8'd16;
        scale_col = 32'd65536;
        scale_row = 32'd65536;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_item(directed[i]);

        // Phases of register settings, extremes first; about 150 items each
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(bpg_pkg::CFG_RES, 32'd1);
                    write_reg(bpg_pkg::CFG_SCOL, 32'hFFFFFFFF);
                    write_reg(bpg_pkg::CFG_SROW, 32'd0);
                end
                1: begin
                    write_reg(bpg_pkg::CFG_RES, 32'd255);
                    write_reg(bpg_pkg::CFG_SCOL, 32'd0);
                    write_reg(bpg_pkg::CFG_SROW, 32'hFFFFFFFF);
                    calm = 1'b1;
                end
                2: begin
                    calm = 1'b0;
                    write_reg(bpg_pkg::CFG_RES, 32'd0);
                    write_reg(CFG_NONE, $urandom);
                end
                default: begin
                    write_reg(bpg_pkg::CFG_RES, $urandom);
                    write_reg(bpg_pkg::CFG_SCOL, $urandom);
                    write_reg(bpg_pkg::CFG_SROW, $urandom);
                end
            endcase
            for (int n = 0; n < 150; n++) begin
                if (ph == 0 && n == 40) hold_req = 1'b1;
                if (ph == 3 && n == 60) while (pending_vertices.size() != 0) @(negedge i_clk);
                send_item(random_item());
            end
        end

        drain();
        if (n_err == 0) $display("tb_bezier_patch_grid_point_unit: done, clean");
        else $display("tb_bezier_patch_grid_point_unit: done, errors");
        $finish;
    end

endmodule
